>>> design/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg - shared definitions for the URL percent decoder
// Character codes, queue sizing and the result bundle passed front to back.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int unsigned MaxResults = 6;
  localparam int unsigned RawDepth   = 5;
  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] CharPct  = 8'h25;  // '%'
  localparam logic [7:0] CharU    = 8'h75;  // 'u'
  localparam logic [7:0] CharNul  = 8'h00;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] ContLead = 8'h80;

  // All results caused by one input item, in emission order from index 0.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [2:0]                 count;    // 1..MaxResults
    logic                       msg_end;  // last byte closes the message
  } bundle_t;

endpackage

>>> design/upd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front - escape parser
// Accepts one encoded byte per cycle while the bundle queue has room, tracks the
// open escape and builds the bundle of decoded bytes that the byte completes.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_char_i,
  input  logic            in_final_i,
  output logic            in_ready_o,
  input  logic            q_full_i,
  output logic            push_o,
  output upd_pkg::bundle_t bundle_o
);

  typedef enum logic [2:0] {
    PhPlain, PhPct, PhOneHex, PhU0, PhU1, PhU2, PhU3
  } phase_e;

  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [11:0] acc_q, acc_d;
  logic        disc_q, disc_d;
  logic [7:0]  raw_q [upd_pkg::RawDepth];
  logic [7:0]  raw_d [upd_pkg::RawDepth];

  logic        accept;
  logic [2:0]  n;
  logic [upd_pkg::MaxResults-1:0][7:0] seq;
  logic        ended;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    logic [4:0]  hx;
    logic        flush;
    logic        take;
    logic [7:0]  tb;
    logic [15:0] u;
    logic [2:0]  idx;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    disc_d  = disc_q;
    raw_d   = raw_q;
    n       = 3'd0;
    seq     = '0;
    ended   = 1'b0;
    flush   = 1'b0;
    take    = 1'b0;
    tb      = in_char_i;
    hx      = hex_decode(in_char_i);
    u       = {acc_q, hx[3:0]};
    idx     = 3'd0;

    if (disc_q) begin
      // drop everything up to and including the final byte
      if (in_final_i) begin
        disc_d  = 1'b0;
        phase_d = PhPlain;
        cnt_d   = 3'd0;
        acc_d   = 12'd0;
      end
    end else begin
      unique case (phase_q)
        PhPct: begin
          if (hx[4]) begin
            acc_d = {8'd0, hx[3:0]};
            raw_d[cnt_q] = in_char_i;
            cnt_d   = cnt_q + 3'd1;
            phase_d = PhOneHex;
          end else if (in_char_i == upd_pkg::CharU) begin
            acc_d = 12'd0;
            raw_d[cnt_q] = in_char_i;
            cnt_d   = cnt_q + 3'd1;
            phase_d = PhU0;
          end else begin
            flush = 1'b1;
            take  = 1'b1;
          end
        end
        PhOneHex: begin
          take = 1'b1;
          if (hx[4]) begin
            tb = {acc_q[3:0], hx[3:0]};
          end else begin
            flush = 1'b1;
          end
        end
        PhU0, PhU1, PhU2, PhU3: begin
          if (!hx[4]) begin
            flush = 1'b1;
            take  = 1'b1;
          end else if (phase_q == PhU3) begin
            seq[0]  = upd_pkg::Lead3 | {4'h0, u[15:12]};
            seq[1]  = upd_pkg::ContLead | {2'b0, u[11:6]};
            seq[2]  = upd_pkg::ContLead | {2'b0, u[5:0]};
            n       = 3'd3;
            cnt_d   = 3'd0;
            phase_d = PhPlain;
            acc_d   = 12'd0;
          end else begin
            acc_d = u[11:0];
            raw_d[cnt_q] = in_char_i;
            cnt_d = cnt_q + 3'd1;
            unique case (phase_q)
              PhU0:    phase_d = PhU1;
              PhU1:    phase_d = PhU2;
              default: phase_d = PhU3;
            endcase
          end
        end
        default: take = 1'b1;
      endcase

      // emit the malformed escape raw before the current byte
      if (flush) begin
        for (int i = 0; i < upd_pkg::RawDepth; i++) begin
          if (3'(i) < cnt_q) begin
            seq[i] = raw_q[i];
          end
        end
        n = cnt_q;
      end

      if (take) begin
        cnt_d   = 3'd0;
        phase_d = PhPlain;
        acc_d   = 12'd0;
        if (tb == upd_pkg::CharNul) begin
          seq[n] = upd_pkg::CharNul;
          n      = n + 3'd1;
          ended  = 1'b1;
        end else if (tb == upd_pkg::CharPct) begin
          raw_d[0] = upd_pkg::CharPct;
          cnt_d    = 3'd1;
          phase_d  = PhPct;
        end else begin
          seq[n] = tb;
          n      = n + 3'd1;
        end
      end

      if (ended) begin
        disc_d = !in_final_i;
      end else if (in_final_i) begin
        // close an escape left open at the end of the message
        for (int i = 0; i < upd_pkg::RawDepth; i++) begin
          if (3'(i) < cnt_d) begin
            idx      = n + 3'(i);
            seq[idx] = raw_d[i];
          end
        end
        n       = n + cnt_d;
        cnt_d   = 3'd0;
        phase_d = PhPlain;
        acc_d   = 12'd0;
      end
    end
  end

  assign push_o           = accept && (n != 3'd0);
  assign bundle_o.bytes   = seq;
  assign bundle_o.count   = n;
  assign bundle_o.msg_end = ended || in_final_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPlain;
      cnt_q   <= 3'd0;
      acc_q   <= 12'd0;
      disc_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      disc_q  <= disc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q <= raw_d;
    end
  end

endmodule

>>> design/upd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_fifo - result bundle queue
// Small register queue that decouples the parser from the byte serializer.
// ----------------------------------------------------------------------------
module upd_fifo #(
  parameter int unsigned Depth = upd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  upd_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output upd_pkg::bundle_t data_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  upd_pkg::bundle_t mem_q [Depth];
  logic [AddrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> design/upd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back - byte serializer
// Walks the head bundle one byte per cycle into the output register while the receiver is ready.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  upd_pkg::bundle_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             run_end_o,
  output logic             message_end_o
);

  logic [2:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       run_q, msg_q;
  logic       load, last;

  assign load  = !empty_i && (!valid_q || out_ready_i);
  assign last  = (idx_q == head_i.count - 3'd1);
  assign pop_o = load && last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = last ? 3'd0 : idx_q + 3'd1;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.bytes[idx_q];
      run_q  <= last;
      msg_q  <= last && head_i.msg_end;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_char_o    = char_q;
  assign run_end_o     = run_q;
  assign message_end_o = msg_q;

endmodule

>>> design/url_percent_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_core - URL percent decoder with %uXXXX escapes
// A decoded byte passes the bundle queue, then the output register.
// Throughput: one input byte per cycle while the queue has room; output moves
// one byte per cycle while the receiver is ready, so an input with k results
// holds the serializer k bytes; the queue (QueueDepth entries) takes bursts.
// Reset: asynchronous, active low; parser returns to plain text, queue empty.
// ----------------------------------------------------------------------------
module url_percent_decoder_core #(
  parameter int unsigned QueueDepth = upd_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tlast,   // in_final
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,   // message_end
  output logic       m_axis_tuser    // [0] run_end
);

  upd_pkg::bundle_t push_data, head;
  logic             push, pop, full, empty;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_char_i  (s_axis_tdata),
    .in_final_i (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .q_full_i   (full),
    .push_o     (push),
    .bundle_o   (push_data)
  );

  upd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (empty)
  );

  upd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_char_o    (m_axis_tdata),
    .run_end_o     (m_axis_tuser),
    .message_end_o (m_axis_tlast)
  );

endmodule

>>> bench/url_percent_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_core_tb - self-checking bench for the URL decoder core
// Streams encoded URL text through the core and compares every decoded byte,
// with its run_end and message_end flags, against a predictor built into a
// small scoreboard. A directed set covers the extremes and each special case.
// Random messages follow, a mix of plain bytes and well-formed escapes with random
// content, plus broken escapes and noise. Both sides idle at random, and the receiver holds
// off once for a long stretch so that the core backs up.
// ----------------------------------------------------------------------------
module url_percent_decoder_core_tb;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
    logic       message_end;
  } decoded_byte_t;

  class url_decode_checker;
    typedef enum logic [2:0] {
      PhPlain, PhPct, PhOneHex, PhU0, PhU1, PhU2, PhU3
    } phase_e;

    phase_e          phase;
    logic [7:0]      raw_bytes[upd_pkg::RawDepth];
    int unsigned     raw_count;
    logic [15:0]     code;
    bit              dropping;
    bit              nul_seen;
    logic [7:0]      burst[$];
    decoded_byte_t   decoded_bytes[$];
    int unsigned     errors;

    function new();
      phase     = PhPlain;
      raw_count = 0;
      code      = '0;
      dropping  = 1'b0;
      errors    = 0;
    endfunction

    static function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
    endfunction

    // At most MaxResults bytes leave per input; drop the rest.
    function void put_byte(logic [7:0] c);
      if (burst.size() < upd_pkg::MaxResults) burst = {burst, c};
    endfunction

    function void push_raw(logic [7:0] c);
      if (raw_count < upd_pkg::RawDepth) begin
        raw_bytes[raw_count] = c;
        raw_count++;
      end
    endfunction

    function void flush_raw();
      for (int i = 0; i < raw_count; i++) put_byte(raw_bytes[i]);
      raw_count = 0;
      phase     = PhPlain;
      code      = '0;
    endfunction

    function void take_plain(logic [7:0] c);
      raw_count = 0;
      phase     = PhPlain;
      code      = '0;
      if (c == upd_pkg::CharNul) begin
        put_byte(upd_pkg::CharNul);
        nul_seen = 1'b1;
      end else if (c == upd_pkg::CharPct) begin
        push_raw(upd_pkg::CharPct);
        phase = PhPct;
      end else begin
        put_byte(c);
      end
    endfunction

    // Advance the decoder by one accepted byte and queue what it must emit.
    function void note_encoded_byte(logic [7:0] c, logic last);
      int            h;
      decoded_byte_t d;
      if (dropping) begin
        if (last) begin
          dropping  = 1'b0;
          phase     = PhPlain;
          raw_count = 0;
          code      = '0;
        end
        return;
      end
      burst.delete();
      nul_seen = 1'b0;
      h = hex_value(c);
      case (phase)
        PhPct: begin
          if (h >= 0) begin
            code = 16'(h);
            push_raw(c);
            phase = PhOneHex;
          end else if (c == upd_pkg::CharU) begin
            code = '0;
            push_raw(c);
            phase = PhU0;
          end else begin
            flush_raw();
            take_plain(c);
          end
        end
        PhOneHex: begin
          if (h >= 0) begin
            take_plain({code[3:0], h[3:0]});
          end else begin
            flush_raw();
            take_plain(c);
          end
        end
        PhU0, PhU1, PhU2, PhU3: begin
          if (h >= 0) begin
            code = {code[11:0], h[3:0]};
            if (phase == PhU3) begin
              put_byte(upd_pkg::Lead3 | {4'h0, code[15:12]});
              put_byte(upd_pkg::ContLead | {2'b00, code[11:6]});
              put_byte(upd_pkg::ContLead | {2'b00, code[5:0]});
              raw_count = 0;
              phase     = PhPlain;
              code      = '0;
            end else begin
              push_raw(c);
              phase = phase_e'(phase + 1);
            end
          end else begin
            flush_raw();
            take_plain(c);
          end
        end
        default: take_plain(c);
      endcase
      if (nul_seen) begin
        if (!last) dropping = 1'b1;
      end else if (last) begin
        flush_raw();
      end
      foreach (burst[i]) begin
        d.out_char    = burst[i];
        d.run_end     = (i == burst.size() - 1);
        d.message_end = d.run_end && (nul_seen || last);
        decoded_bytes = {decoded_bytes, d};
      end
    endfunction

    task report_mismatch(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_decoded_byte(logic [7:0] c, logic run_end, logic message_end);
      decoded_byte_t d;
      if (decoded_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", c));
        return;
      end
      d = decoded_bytes.pop_front();
      if (c !== d.out_char)
        report_mismatch($sformatf("out_char %02h, want %02h", c, d.out_char));
      if (run_end !== d.run_end)
        report_mismatch($sformatf("run_end %b, want %b on %02h", run_end, d.run_end,
                                  d.out_char));
      if (message_end !== d.message_end)
        report_mismatch($sformatf("message_end %b, want %b on %02h", message_end,
                                  d.message_end, d.out_char));
    endtask
  endclass

  localparam int unsigned RandomItems = 330;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_char
  logic       s_axis_tlast  = 1'b0;    // in_final
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] out_char
  logic       m_axis_tlast;            // message_end
  logic       m_axis_tuser;            // [0] run_end

  url_decode_checker sb;
  logic [7:0]        text_q[$];
  int unsigned       items_sent = 0;
  bit                no_gaps    = 1'b0;

  url_percent_decoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_decoded_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_byte(logic [7:0] c, logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_encoded_byte(c, last);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic void add_char(logic [7:0] c);
    text_q = {text_q, c};
  endfunction

  function automatic void add_hex(logic [3:0] v);
    if (v < 10) add_char("0" + 8'(v));
    else if ($urandom_range(0, 1) != 0) add_char("A" + 8'(v) - 8'd10);
    else add_char("a" + 8'(v) - 8'd10);
  endfunction

  // Open an escape of random depth: '%', '%X', or '%u' with up to three digits.
  function automatic void add_open_escape();
    int unsigned k;
    add_char(upd_pkg::CharPct);
    k = $urandom_range(0, 5);
    if (k == 1) begin
      add_hex(4'($urandom));
    end else if (k >= 2) begin
      add_char(upd_pkg::CharU);
      repeat (k - 2) add_hex(4'($urandom));
    end
  endfunction

  function automatic void build_message();
    int unsigned r;
    logic [15:0] v;
    logic [7:0]  c;
    no_gaps = ($urandom_range(0, 5) == 0);
    repeat ($urandom_range(1, 10)) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        c = 8'($urandom_range(1, 255));
        if (c == upd_pkg::CharPct) c = "+";
        add_char(c);
      end else if (r < 55) begin
        v = ($urandom_range(0, 19) == 0) ? 16'h0 : 16'($urandom_range(1, 255));
        add_char(upd_pkg::CharPct);
        add_hex(v[7:4]);
        add_hex(v[3:0]);
      end else if (r < 70) begin
        v = 16'($urandom);
        add_char(upd_pkg::CharPct);
        add_char(upd_pkg::CharU);
        for (int k = 3; k >= 0; k--) add_hex(v[k*4 +: 4]);
      end else if (r < 77) begin
        add_char(upd_pkg::CharPct);
        add_char("2");
        add_char("5");
      end else if (r < 90) begin
        add_open_escape();
        do c = 8'($urandom_range(1, 255));
        while (url_decode_checker::hex_value(c) >= 0 || c == upd_pkg::CharU);
        add_char(c);
      end else if (r < 95) begin
        add_char(upd_pkg::CharNul);
      end else begin
        add_char(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 4) == 0) add_open_escape();
  endfunction

  // Drain side: random ready pattern, with one long hold-off after reset.
  initial begin
    int unsigned cycles;
    int unsigned len;
    int unsigned r;
    bit          held;
    cycles = 0;
    held   = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && cycles >= 300) begin
        m_axis_tready <= 1'b0;
        len  = 400;
        held = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          m_axis_tready <= 1'b1;
          len = $urandom_range(40, 120);
        end else if (r < 55) begin
          m_axis_tready <= 1'b1;
          len = $urandom_range(1, 6);
        end else if (r < 92) begin
          m_axis_tready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          m_axis_tready <= 1'b0;
          len = $urandom_range(10, 40);
        end
      end
      repeat (len) @(posedge clk_i);
      cycles += len;
    end
  end

  initial begin
    int unsigned start;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Byte extremes, lowercase hex.
    text_q = {8'h01, 8'hFF, "%", "4", "a"};
    send_text();
    // Decoded '%' starts a new escape; uppercase hex.
    text_q = {"%", "2", "5", "4", "B"};
    send_text();
    // %u escape, uppercase U is not an escape, escape left open at the end.
    text_q = {"%", "u", "2", "0", "A", "c", "%", "U", "%", "u", "A", "B"};
    send_text();
    // Decoded NUL ends the message; the rest through the last byte is dropped.
    text_q = {"%", "0", "0", "q"};
    send_text();
    // Raw zero byte.
    text_q = {upd_pkg::CharNul};
    send_text();

    start = items_sent;
    while (items_sent - start < RandomItems) begin
      build_message();
      send_text();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.decoded_bytes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("url_percent_decoder_core_tb: clean");
    end else begin
      $display("url_percent_decoder_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("url_percent_decoder_core_tb: errors");
    $finish;
  end

endmodule
